FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Clock and reset names clk and rst_n are taken from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define RRQQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside of reset.
`define RRQQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/rrqq_pkg.sv
// Shared types and constants of the round-robin quantum queue.
// No dependencies; used by rrqq_ring, rrqq_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rrqq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_W         = 5;
  localparam int DATA_W        = 32;
  localparam int QNT_W         = 16;
  localparam int CNT_OUT_W     = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Action codes; the fourth code is unused and leaves the queue alone
  typedef enum logic [1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_SVC = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // One result item as handed from the controller to the output register
  typedef struct packed {
    status_t               status;
    logic [DATA_W-1:0]     data;
    logic                  requeued;
    logic [CNT_OUT_W-1:0]  count;
    logic                  is_empty;
    logic                  is_full;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/round_robin_quantum_queue_core.sv
// Channel   Handshake         Fields
// in_       valid / stall     action, value_in, quantum
// out_      valid / stall     status, data_out, requeued, count, is_empty, is_full
// cfg_      valid / ready     data (capacity)
//
// For each item the head entry is read from the ring memory in the accept cycle,
// and the result and any tail write happen once the output slot is free.
// The memory's read is registered; one item is in work
// at a time, and the next is taken while a result waits in the output register.
// A stalled output holds the finishing item, which then holds in_stall high.
// Reset (rst_n low, synchronous) empties the queue and sets capacity to 16.
//
// Top level: capacity register, output register, controller and ring store.
// Depends on rrqq_pkg, rrqq_ctrl, rrqq_ring and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module round_robin_quantum_queue_core
  import rrqq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_action,
  input  wire logic signed [DATA_W-1:0] in_value_in,
  input  wire logic [QNT_W-1:0]         in_quantum,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_status,
  output logic signed [DATA_W-1:0]      out_data_out,
  output logic                          out_requeued,
  output logic [CNT_OUT_W-1:0]          out_count,
  output logic                          out_is_empty,
  output logic                          out_is_full,
  // configuration
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CAP_W-1:0]         cfg_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0]  cap_r;
  logic              out_valid_r;
  result_t           out_r;
  logic              slot_free;
  logic              res_valid;
  result_t           res;
  logic              rd_en, wr_en;
  logic [PTR_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] rd_data, wr_data;

  // Capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  rrqq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_value   (in_value_in),
    .in_quantum (in_quantum),
    .cap_cfg    (cap_r),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  rrqq_ring #(.DEPTH(DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_data_out = out_r.data;
  assign out_requeued = out_r.requeued;
  assign out_count    = out_r.count;
  assign out_is_empty = out_r.is_empty;
  assign out_is_full  = out_r.is_full;

  // Checks
  `RRQQ_ASSERT(a_one_item_in_work, (in_valid && !in_stall) |=> in_stall, "item accepted while busy")
  `RRQQ_NEVER(a_no_overwrite, res_valid && !slot_free, "result overwrote waiting item")
  `RRQQ_ASSERT(a_requeue_positive, (res_valid && res.requeued) |-> (!res.data[DATA_W-1] && res.data != '0 && res.status == ST_DONE), "requeued remainder not positive")
  `RRQQ_ASSERT(a_empty_reject, (res_valid && res.status == ST_EMPTY) |-> (res.is_empty && res.count == '0), "empty rejection with entries held")

endmodule

`default_nettype wire

FILE: hw/rtl/rrqq_ring.sv
// Ring store of the queue: one write port, one read port, registered read.
// Depends on rrqq_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module rrqq_ring
  import rrqq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [PTR_W-1:0]  wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [PTR_W-1:0]  rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrqq_ctrl.sv
// Queue controller: pointers, occupancy, head read and read-modify-write.
// Depends on rrqq_pkg; drives the ports of rrqq_ring.
`timescale 1ns / 1ps
`default_nettype none

module rrqq_ctrl
  import rrqq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input item
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_action,
  input  wire logic [DATA_W-1:0] in_value,
  input  wire logic [QNT_W-1:0]  in_quantum,
  // configuration and output slot
  input  wire logic [CAP_W-1:0]  cap_cfg,
  input  wire logic              slot_free,
  output logic                   res_valid,
  output result_t                res,
  // ring store
  output logic                   rd_en,
  output logic      [PTR_W-1:0]  rd_addr,
  input  wire logic [DATA_W-1:0] rd_data,
  output logic                   wr_en,
  output logic      [PTR_W-1:0]  wr_addr,
  output logic      [DATA_W-1:0] wr_data
);

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        act_r;
  logic [DATA_W-1:0] val_r;
  logic [QNT_W-1:0]  qnt_r;

  logic              fire;
  logic [CNT_W-1:0]  eff_cap;
  logic [DATA_W:0]   diff;
  logic              sat;
  logic [DATA_W-1:0] rem;
  logic              rem_pos;
  logic              push, pop;
  logic [DATA_W-1:0] push_val;
  status_t           status;
  logic [DATA_W-1:0] data;
  logic              req;

  // Effective capacity: zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    if (cap_cfg == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CMP_W'(cap_cfg) > CMP_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_cfg);
    end
  end

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs: head read on accept, finish once the output slot is free
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    fire     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
      end
      S_EXEC: begin
        fire = slot_free;
      end
      default: ;
    endcase
  end

  assign rd_addr   = head_r;
  assign res_valid = fire;

  // Saturating head minus quantum
  assign diff    = {rd_data[DATA_W-1], rd_data} - {{(DATA_W+1-QNT_W){1'b0}}, qnt_r};
  assign sat     = diff[DATA_W] != diff[DATA_W-1];
  assign rem     = sat ? {1'b1, {(DATA_W-1){1'b0}}} : diff[DATA_W-1:0];
  assign rem_pos = !rem[DATA_W-1] && (rem != '0);

  // Action decode
  always_comb begin
    status   = ST_DONE;
    data     = '0;
    req      = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    push_val = val_r;
    case (act_r)
      ACT_ENQ: begin
        if (cnt_r >= eff_cap) status = ST_FULL;
        else                  push   = 1'b1;
      end
      ACT_DEQ: begin
        if (cnt_r == '0) begin
          status = ST_EMPTY;
        end else begin
          pop  = 1'b1;
          data = rd_data;
        end
      end
      ACT_SVC: begin
        if (cnt_r == '0) begin
          status = ST_EMPTY;
        end else begin
          // head leaves first, so a requeue always has room
          pop      = 1'b1;
          data     = rem;
          push     = rem_pos;
          req      = rem_pos;
          push_val = rem;
        end
      end
      default: ;
    endcase
  end

  // Pointer and occupancy update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop)  head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    if (push) tail_nxt = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  // Write-back of the appended entry; the next head read only follows once it is written
  assign wr_en   = fire && push;
  assign wr_addr = tail_r;
  assign wr_data = push_val;

  // Result
  always_comb begin
    res.status   = status;
    res.data     = data;
    res.requeued = req;
    res.count    = CNT_OUT_W'(cnt_nxt);
    res.is_empty = cnt_nxt == '0;
    res.is_full  = cnt_nxt >= eff_cap;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  // Item fields held while it executes
  always_ff @(posedge clk) begin
    if (rd_en) begin
      act_r <= in_action;
      val_r <= in_value;
      qnt_r <= in_quantum;
    end
  end

endmodule

`default_nettype wire

FILE: test/rrqq_queue_checker.sv
`timescale 1ns / 1ps
// Result checker for round_robin_quantum_queue_core: keeps its own copy of the ring and the
// capacity register, predicts one result per accepted item and compares every field.
// Depends on rrqq_pkg.
module rrqq_queue_checker
  import rrqq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic signed [DATA_W-1:0] in_value_in,
  input  logic [QNT_W-1:0]         in_quantum,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [1:0]               out_status,
  input  logic signed [DATA_W-1:0] out_data_out,
  input  logic                     out_requeued,
  input  logic [CNT_OUT_W-1:0]     out_count,
  input  logic                     out_is_empty,
  input  logic                     out_is_full,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_data,
  output int                       fail_count,
  output int                       awaiting
);

  localparam longint SAT_MIN = -64'sd2147483648;

  // shadow queue state
  logic [DATA_W-1:0] ring_copy [DEPTH];
  int unsigned       head_ptr;
  int unsigned       tail_ptr;
  int unsigned       fill;
  logic [CAP_W-1:0]  capacity;
  result_t           expected_q [$];

  task automatic report_error(input string msg);
    $display("%0t ns: rrqq mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // capacity 0 behaves as 1, anything above the built depth as the depth
  function automatic int unsigned usable_cap(input logic [CAP_W-1:0] c);
    int unsigned cv;
    cv = 32'(c);
    if (cv == 0) return 1;
    if (cv > DEPTH) return DEPTH;
    return cv;
  endfunction

  task automatic push_entry(input logic [DATA_W-1:0] v);
    ring_copy[tail_ptr] = v;
    tail_ptr = (tail_ptr + 1) % DEPTH;
    fill++;
  endtask

  // apply one item to the shadow queue and build the result it should give
  task automatic step_queue(input logic [1:0] act, input logic [DATA_W-1:0] val,
                            input logic [QNT_W-1:0] qnt, output result_t res);
    int unsigned       lim;
    logic [DATA_W-1:0] head_val;
    longint            diff;
    lim = usable_cap(capacity);
    res = '0;
    res.status = ST_DONE;
    case (act)
      ACT_ENQ: begin
        if (fill >= lim) res.status = ST_FULL;
        else push_entry(val);
      end
      ACT_DEQ, ACT_SVC: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          head_val = ring_copy[head_ptr];
          head_ptr = (head_ptr + 1) % DEPTH;
          fill--;
          if (act == ACT_DEQ) begin
            res.data = head_val;
          end else begin
            // head was removed first, so a positive remainder always fits
            diff = longint'($signed(head_val)) - longint'(qnt);
            if (diff < SAT_MIN) diff = SAT_MIN;
            res.data = diff[DATA_W-1:0];
            if (diff > 0) begin
              push_entry(res.data);
              res.requeued = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res.count    = fill[CNT_OUT_W-1:0];
    res.is_empty = (fill == 0);
    res.is_full  = (fill >= lim);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      head_ptr = 0;
      tail_ptr = 0;
      fill     = 0;
      capacity = CAP_RESET;
      expected_q.delete();
    end else begin
      // results first: an item taken on this edge cannot have its result out yet
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_error($sformatf("result with nothing expected (status %0d data %0h)",
                                 out_status, out_data_out));
        end else begin
          want = expected_q.pop_front();
          check_field("status", out_status, want.status);
          check_field("data_out", out_data_out, want.data);
          check_field("requeued", out_requeued, want.requeued);
          check_field("count", out_count, want.count);
          check_field("is_empty", out_is_empty, want.is_empty);
          check_field("is_full", out_is_full, want.is_full);
        end
      end
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (in_valid && !in_stall) begin
        step_queue(in_action, in_value_in, in_quantum, want);
        expected_q.push_back(want);
      end
    end
    awaiting <= expected_q.size();
  end

endmodule

FILE: test/tb_round_robin_quantum_queue_core.sv
`timescale 1ns / 1ps
// Top of the round_robin_quantum_queue_core bench: clock, reset, item and capacity stimulus,
// random idling on both channels and the final verdict. Depends on rrqq_pkg,
// rrqq_queue_checker and the core.
module tb_round_robin_quantum_queue_core;
  import rrqq_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 1000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_action = ACT_ENQ;
  logic signed [DATA_W-1:0] in_value_in = '0;
  logic [QNT_W-1:0]         in_quantum = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_data_out;
  logic                     out_requeued;
  logic [CNT_OUT_W-1:0]     out_count;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_data = '0;
  int                       fail_count;
  int                       awaiting;
  logic                     steady = 1'b0;

  round_robin_quantum_queue_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_value_in  (in_value_in),
    .in_quantum   (in_quantum),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_requeued (out_requeued),
    .out_count    (out_count),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  rrqq_queue_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_value_in  (in_value_in),
    .in_quantum   (in_quantum),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_requeued (out_requeued),
    .out_count    (out_count),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .awaiting     (awaiting)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4, 5: return $urandom_range(1, 150000);
      6:       return -$urandom_range(1, 150000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [QNT_W-1:0] pick_quantum();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return 16'hFFFF;
    if (r < 50) return QNT_W'($urandom_range(1, 2000));
    return QNT_W'($urandom_range(0, 65535));
  endfunction

  // result side: random stall bursts unless running steady
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (steady) begin
        out_stall <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 35);
        hold = pick_gap();
      end
    end
  end

  // one item, with an optional idle gap ahead of it; returns on the accepting edge
  task automatic send_item(input logic [1:0] act, input logic [DATA_W-1:0] val,
                           input logic [QNT_W-1:0] qnt);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_value_in <= val;
    in_quantum  <= qnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result, plus a short pause
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_until_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // watchdog: too long without any handshake ends the run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_round_robin_quantum_queue_core: done, errors");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] phase_cap [8];
    int               enq_pct [8];
    int               r;
    logic [1:0]       act;
    phase_cap = '{5'd31, 5'd0, 5'd3, 5'd16, 5'd1, 5'd8, 5'd16, 5'd16};
    enq_pct   = '{55, 50, 45, 40, 50, 45, 50, 75};
    phase_cap[6] = CAP_W'($urandom_range(1, 31));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: both removals rejected, unused code is a no-op
    send_item(ACT_DEQ, '0, 16'd7);
    send_item(ACT_SVC, '0, 16'd7);
    send_item(ACT_UNUSED, 32'h1234_5678, 16'd1);
    // extremes of the value field
    send_item(ACT_ENQ, 32'h7FFF_FFFF, '0);
    send_item(ACT_ENQ, 32'h8000_0000, '0);
    send_item(ACT_ENQ, 32'h0000_0000, '0);
    send_item(ACT_ENQ, 32'h0000_0001, '0);
    send_item(ACT_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ACT_UNUSED, '0, '0);
    // service: requeue, saturation at the minimum, zero quantum both ways, drop
    send_item(ACT_SVC, '0, 16'hFFFF);
    send_item(ACT_SVC, '0, 16'd1);
    send_item(ACT_SVC, '0, 16'd0);
    send_item(ACT_SVC, '0, 16'd0);
    send_item(ACT_SVC, '0, 16'd1);
    send_item(ACT_DEQ, '0, '0);
    send_item(ACT_SVC, '0, 16'd1);

    // small capacity: full reject, then service with requeue while full
    write_capacity(5'd2);
    send_item(ACT_ENQ, 32'd5, '0);
    send_item(ACT_ENQ, 32'd9, '0);
    send_item(ACT_ENQ, 32'd11, '0);
    send_item(ACT_SVC, '0, 16'd2);

    // capacity lowered below the fill level
    write_capacity(5'd1);
    send_item(ACT_ENQ, 32'd13, '0);
    send_item(ACT_DEQ, '0, '0);
    send_item(ACT_ENQ, 32'd17, '0);

    // zero capacity behaves as one
    write_capacity(5'd0);
    send_item(ACT_DEQ, '0, '0);
    send_item(ACT_ENQ, 32'd100, '0);
    send_item(ACT_ENQ, 32'd101, '0);

    // random phases, each under its own capacity; one runs without idling
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_cap[p]);
      steady = (p == 3);
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(0, 99);
        if (r < enq_pct[p]) act = ACT_ENQ;
        else if (r >= 96) act = ACT_UNUSED;
        else if ($urandom_range(0, 9) < 4) act = ACT_DEQ;
        else act = ACT_SVC;
        send_item(act, pick_value(), pick_quantum());
      end
    end
    steady = 1'b0;

    wait_until_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && awaiting == 0)
      $display("tb_round_robin_quantum_queue_core: done, clean");
    else
      $display("tb_round_robin_quantum_queue_core: done, errors");
    $finish;
  end

endmodule
